// File: design/pcrc16_pkg.sv
package pcrc16_pkg;

	localparam int unsigned CRC_W      = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CRC_W-1:0] POLY_RESET = 16'h8005;

	// register map of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY        = 3'd0,
		REG_INIT_VALUE  = 3'd1,
		REG_REFLECT_IN  = 3'd2,
		REG_REFLECT_OUT = 3'd3,
		REG_CONTINUE    = 3'd4,
		REG_XOR_OUT     = 3'd5
	} pcrc16_reg_idx_t;

	typedef struct packed {
		logic [CRC_W-1:0] poly;
		logic [CRC_W-1:0] init_value;
		logic             reflect_in;
		logic             reflect_out;
		logic             continue_mode;
		logic [CRC_W-1:0] xor_out;
	} pcrc16_cfg_t;

	function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int k = 0; k < BYTE_W; k++) begin
			r[BYTE_W-1-k] = v[k];
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] rev16(input logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] r;
		for (int k = 0; k < CRC_W; k++) begin
			r[CRC_W-1-k] = v[k];
		end
		return r;
	endfunction

endpackage

// File: design/pcrc16_in_if.sv
interface pcrc16_in_if;
	logic                              valid;
	logic                              ready;
	logic [pcrc16_pkg::BYTE_W-1:0]     data_byte;
	logic                              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: design/pcrc16_out_if.sv
interface pcrc16_out_if;
	logic                             valid;
	logic                             ready;
	logic [pcrc16_pkg::CRC_W-1:0]     crc_value;

	modport source (output valid, output crc_value, input ready);
	modport sink   (input valid, input crc_value, output ready);
endinterface

// File: design/parameterized_crc16_engine.sv
// Configurable CRC-16 over a byte stream (poly, start value, input/output
// reflection, continuation mode, final XOR). One byte is accepted per clock,
// sustained, for as long as results are taken. A finished CRC is offered on the
// output channel from the result register: its last byte sits in the input
// register first, and the result register loads when that byte folds. The
// one-byte-per-clock rate holds because all eight XOR-shift steps of the fold
// run combinationally between the input register and the running CRC / result
// register. A last byte stalls only while an earlier result waits untaken.
// Only bytes flagged last_byte produce an item.
// The first byte after reset or after a last byte opens a new message and
// loads the start value. Configuration writes take effect at once and should
// be done with the block idle.
module parameterized_crc16_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcrc16_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcrc16_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	pcrc16_in_if.sink                           in_ch,
	pcrc16_out_if.source                        out_ch
);

	pcrc16_pkg::pcrc16_cfg_t cfg;

	// input stage
	logic                              valid_s1;
	logic [pcrc16_pkg::BYTE_W-1:0]     data_s1;
	logic                              last_s1;

	// running CRC and message-open flag
	logic [pcrc16_pkg::CRC_W-1:0]      crc_q;
	logic                              in_msg_q;

	// result register
	logic                              out_valid_q;
	logic [pcrc16_pkg::CRC_W-1:0]      out_crc_q;

	logic [pcrc16_pkg::CRC_W-1:0]      crc_next;
	logic [pcrc16_pkg::CRC_W-1:0]      crc_final;
	logic                              advance;

	pcrc16_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pcrc16_datapath u_dp (
		.cfg       (cfg),
		.crc_cur   (crc_q),
		.in_msg    (in_msg_q),
		.data_byte (data_s1),
		.crc_next  (crc_next),
		.crc_final (crc_final)
	);

	// A non-last byte never needs the result register, so it folds even
	// while a finished CRC waits downstream.
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);

	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			in_msg_q <= 1'b0;
		end else if (advance) begin
			crc_q    <= crc_next;
			in_msg_q <= !last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_crc_q <= crc_final;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.crc_value = out_crc_q;

`ifndef SYNTHESIS
	// a result appears only after a last byte went through the fold
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && last_s1))
		else $error("result raised without a last byte");

	// a last byte closes the message, so the next byte reloads the start value
	a_last_closes_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> !in_msg_q)
		else $error("message still open after last byte");

	// a stalled input stage keeps its byte and the running CRC
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1) && $stable(crc_q)))
		else $error("input stage lost its byte while stalled");

	// a waiting result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !(advance && last_s1))
		else $error("result overwritten while waiting");
`endif

endmodule

// File: design/pcrc16_cfg_regs.sv
module pcrc16_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcrc16_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcrc16_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output pcrc16_pkg::pcrc16_cfg_t             cfg
);

	pcrc16_pkg::pcrc16_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly          <= pcrc16_pkg::POLY_RESET;
			cfg_q.init_value    <= '0;
			cfg_q.reflect_in    <= 1'b0;
			cfg_q.reflect_out   <= 1'b0;
			cfg_q.continue_mode <= 1'b0;
			cfg_q.xor_out       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pcrc16_pkg::REG_POLY:        cfg_q.poly          <= cfg_wdata;
				pcrc16_pkg::REG_INIT_VALUE:  cfg_q.init_value    <= cfg_wdata;
				pcrc16_pkg::REG_REFLECT_IN:  cfg_q.reflect_in    <= cfg_wdata[0];
				pcrc16_pkg::REG_REFLECT_OUT: cfg_q.reflect_out   <= cfg_wdata[0];
				pcrc16_pkg::REG_CONTINUE:    cfg_q.continue_mode <= cfg_wdata[0];
				pcrc16_pkg::REG_XOR_OUT:     cfg_q.xor_out       <= cfg_wdata;
				default: ; // unmapped index: write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/pcrc16_datapath.sv
module pcrc16_datapath (
	input  pcrc16_pkg::pcrc16_cfg_t             cfg,
	input  logic [pcrc16_pkg::CRC_W-1:0]        crc_cur,
	input  logic                                in_msg,
	input  logic [pcrc16_pkg::BYTE_W-1:0]       data_byte,
	output logic [pcrc16_pkg::CRC_W-1:0]        crc_next,
	output logic [pcrc16_pkg::CRC_W-1:0]        crc_final
);

	logic [pcrc16_pkg::CRC_W-1:0]  start;
	logic [pcrc16_pkg::BYTE_W-1:0] b;

	always_comb begin
		if (in_msg) begin
			start = crc_cur;
		end else if (cfg.reflect_out && cfg.continue_mode) begin
			start = pcrc16_pkg::rev16(cfg.init_value);
		end else begin
			start = cfg.init_value;
		end
		b = cfg.reflect_in ? pcrc16_pkg::rev8(data_byte) : data_byte;
	end

	// eight MSB-first shift/XOR steps, one per message bit
	always_comb begin
		logic [pcrc16_pkg::CRC_W-1:0] c;
		c = start ^ {b, {(pcrc16_pkg::CRC_W - pcrc16_pkg::BYTE_W){1'b0}}};
		for (int k = 0; k < pcrc16_pkg::BYTE_W; k++) begin
			if (c[pcrc16_pkg::CRC_W-1]) begin
				c = {c[pcrc16_pkg::CRC_W-2:0], 1'b0} ^ cfg.poly;
			end else begin
				c = {c[pcrc16_pkg::CRC_W-2:0], 1'b0};
			end
		end
		crc_next = c;
	end

	assign crc_final = (cfg.reflect_out ? pcrc16_pkg::rev16(crc_next) : crc_next)
		^ cfg.xor_out;

endmodule
